/* design/shp_pkg.sv */
// ----------------------------------------------------------------------------
// shp_pkg : shared types and constants of the 3x3 sharpen / band threshold core
// Frame geometry, register index codes, register reset values and the
// pixel column type that travels along the window cell chain.
// ----------------------------------------------------------------------------
package shp_pkg;

   localparam int FRAME_WIDTH  = 320;
   localparam int FRAME_HEIGHT = 240;

   localparam int PIX_W     = 8;
   localparam int COL_W     = $clog2(FRAME_WIDTH);
   localparam int ROW_W     = $clog2(FRAME_HEIGHT);
   localparam int OUT_ROW_W = 8;
   localparam int OUT_COL_W = 9;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SHARPEN_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_ENABLE  = 3'd3;

   localparam logic [PIX_W-1:0] GAIN_RESET      = 8'd1;
   localparam logic [PIX_W-1:0] BAND_LOW_RESET  = 8'd100;
   localparam logic [PIX_W-1:0] BAND_HIGH_RESET = 8'd140;
   localparam logic             BAND_EN_RESET   = 1'b1;

   // one column of the 3x3 window: top is two rows up, bot is the current row
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } shp_column_type;

endpackage

/* design/sharpen_3x3_band_threshold_core.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_band_threshold_core : streaming 3x3 sharpen with band threshold
// Raster-order 8-bit grayscale pixels in, positioned result pixels out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one pixel per transaction (req_valid / req_stall).
//  - rsp_* channel: one result pixel per transaction with its row, column
//    and rsp_out_last marking the final result caused by an input pixel.
//  - csr_* port: write-only registers (gain, band low/high, band enable);
//    write only while the core is idle.
//  - A pixel gives 0, 1 or 2 results: the finished interior pixel (r-1,c-1)
//    first, then the passthrough of a border pixel (r,c).
//  - A result passes the line store read, window shift, arithmetic and the
//    output register before it is visible.
//  - Throughput: one pixel per clock unless stalled. A pixel with two results
//    (last column, last row) holds the emit stage until both pass the single
//    output register; line store read and write each use one port a cycle.
//  - Pipeline: accept/read -> window cells -> sum/multiply -> output reg.
//    The window is a chain of three column cells that shift on each pixel.
//  - rsp_stall holds the output register; the stages behind it fill up and
//    req_stall rises only when the first stage cannot drain.
//  - Reset (synchronous) empties the pipeline, zeroes the row/column
//    counters and loads the register defaults. Line stores are not cleared.
// ----------------------------------------------------------------------------
module sharpen_3x3_band_threshold_core
   import shp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIX_W-1:0]       req_pixel_in,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_ROW_W-1:0]   rsp_out_row,
   output logic [OUT_COL_W-1:0]   rsp_out_col,
   output logic [PIX_W-1:0]       rsp_out_value,
   output logic                   rsp_out_last,
   // register writes
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // ---------------- configuration registers ----------------
   logic [PIX_W-1:0] gain_ff,  gain_in;
   logic [PIX_W-1:0] low_ff,   low_in;
   logic [PIX_W-1:0] high_ff,  high_in;
   logic             ben_ff,   ben_in;

   always_comb begin
      gain_in = gain_ff;
      low_in  = low_ff;
      high_in = high_ff;
      ben_in  = ben_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SHARPEN_GAIN: gain_in = csr_wr_data;
            CSR_BAND_LOW:     low_in  = csr_wr_data;
            CSR_BAND_HIGH:    high_in = csr_wr_data;
            CSR_BAND_ENABLE:  ben_in  = csr_wr_data[0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         low_ff  <= BAND_LOW_RESET;
         high_ff <= BAND_HIGH_RESET;
         ben_ff  <= BAND_EN_RESET;
      end else begin
         gain_ff <= gain_in;
         low_ff  <= low_in;
         high_ff <= high_in;
         ben_ff  <= ben_in;
      end
   end

   // ---------------- pipeline handshake ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic phase_ff, phase_in;

   logic s1_ready, s2_ready, s3_ready;
   logic s1_adv, s2_adv, s3_done;
   logic o_load_ok;
   logic req_accept;

   // ---------------- position counters (next pixel) ----------------
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   // stage 1: accepted pixel, line store data arrives here
   logic [PIX_W-1:0] s1_px_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_int_ff, s1_bor_ff;

   // stage 2: window holds the 3x3 neighborhood of pixel (r-1,c-1)
   logic [PIX_W-1:0] s2_px_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic             s2_int_ff, s2_bor_ff;

   // stage 3: sums ready, result arithmetic and emit sequencing
   logic [PIX_W-1:0] s3_px_ff;
   logic [ROW_W-1:0] s3_row_ff;
   logic [COL_W-1:0] s3_col_ff;
   logic             s3_int_ff, s3_bor_ff;
   logic [PIX_W-1:0] s3_sum8_ff;
   logic [PIX_W-1:0] s3_ctr_ff;

   // output register
   logic [OUT_ROW_W-1:0] o_row_ff, o_row_in;
   logic [OUT_COL_W-1:0] o_col_ff, o_col_in;
   logic [PIX_W-1:0]     o_val_ff, o_val_in;
   logic                 o_last_ff, o_last_in;

   assign o_load_ok = !rsp_valid_ff || !rsp_stall;

   // emit sequencing in stage 3
   logic s3_any, s3_two, cur_int, cur_last, emit_valid;

   assign s3_any     = s3_int_ff || s3_bor_ff;
   assign s3_two     = s3_int_ff && s3_bor_ff;
   assign cur_int    = s3_int_ff && !phase_ff;
   assign cur_last   = !(s3_two && !phase_ff);
   assign emit_valid = s3_valid_ff && s3_any;

   assign s3_done  = s3_valid_ff && (!s3_any || (o_load_ok && cur_last));
   assign s3_ready = !s3_valid_ff || s3_done;
   assign s2_adv   = s2_valid_ff && s3_ready;
   assign s2_ready = !s2_valid_ff || s2_adv;
   assign s1_adv   = s1_valid_ff && s2_ready;
   assign s1_ready = !s1_valid_ff || s1_adv;

   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   // next-position counters, wrap at frame end
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_accept) begin
         if (col_ff == COL_W'(FRAME_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == ROW_W'(FRAME_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // interior pixel (r-1,c-1) completes at r>=2, c>=2; border passes through
   logic acc_int, acc_bor;

   assign acc_int = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign acc_bor = (row_ff == '0) || (row_ff == ROW_W'(FRAME_HEIGHT - 1)) ||
                    (col_ff == '0) || (col_ff == COL_W'(FRAME_WIDTH - 1));

   // ---------------- line stores ----------------
   logic [PIX_W-1:0] ls_top, ls_mid;

   shp_line_store u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_px   (s1_px_ff),
      .rd_top  (ls_top),
      .rd_mid  (ls_mid)
   );

   // ---------------- window cell chain ----------------
   // cell 2 takes the newest column, cell 0 holds the oldest
   shp_column_type   cell_in  [3];
   shp_column_type   cell_out [3];
   logic [PIX_W-1:0] cell_sum [3];

   assign cell_in[2].top = ls_top;
   assign cell_in[2].mid = ls_mid;
   assign cell_in[2].bot = s1_px_ff;
   assign cell_in[1]     = cell_out[2];
   assign cell_in[0]     = cell_out[1];

   for (genvar g = 0; g < 3; g++) begin : g_cell
      shp_cell u_cell (
         .clock    (clock),
         .shift_en (s1_adv),
         .col_in   (cell_in[g]),
         .col_out  (cell_out[g]),
         .col_sum  (cell_sum[g])
      );
   end

   // neighbor sum excludes the window center (middle cell, middle row)
   logic [PIX_W-1:0] sum8;

   assign sum8 = cell_sum[0] + cell_sum[1] + cell_sum[2] - cell_out[1].mid;

   // ---------------- stage 3 arithmetic ----------------
   // only the low byte of each product matters, the result wraps at 8 bits
   logic [PIX_W-1:0] centre_w, side_w;
   logic [PIX_W-1:0] prod_c, prod_s;
   logic [PIX_W-1:0] acc, int_val;

   assign centre_w = gain_ff + 1'b1;
   assign side_w   = -(gain_ff >> 3);
   assign prod_c   = centre_w * s3_ctr_ff;
   assign prod_s   = side_w * s3_sum8_ff;
   assign acc      = prod_c + prod_s;
   assign int_val  = (ben_ff && (acc > high_ff || acc < low_ff)) ? '0 : acc;

   // ---------------- output register load ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      o_row_in     = o_row_ff;
      o_col_in     = o_col_ff;
      o_val_in     = o_val_ff;
      o_last_in    = o_last_ff;
      phase_in     = phase_ff;
      if (o_load_ok) begin
         rsp_valid_in = emit_valid;
         o_last_in    = cur_last;
         if (cur_int) begin
            o_row_in = OUT_ROW_W'(s3_row_ff - 1'b1);
            o_col_in = OUT_COL_W'(s3_col_ff - 1'b1);
            o_val_in = int_val;
         end else begin
            o_row_in = OUT_ROW_W'(s3_row_ff);
            o_col_in = OUT_COL_W'(s3_col_ff);
            o_val_in = s3_px_ff;
         end
      end
      if (s3_done) begin
         phase_in = 1'b0;
      end else if (emit_valid && o_load_ok) begin
         phase_in = 1'b1;   // first of two results gone
      end
   end

   // ---------------- valid bits ----------------
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_adv);
   assign s3_valid_in = s2_adv || (s3_valid_ff && !s3_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff  <= req_pixel_in;
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
         s1_int_ff <= acc_int;
         s1_bor_ff <= acc_bor;
      end
      if (s1_adv) begin
         s2_px_ff  <= s1_px_ff;
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
         s2_int_ff <= s1_int_ff;
         s2_bor_ff <= s1_bor_ff;
      end
      if (s2_adv) begin
         s3_px_ff   <= s2_px_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_int_ff  <= s2_int_ff;
         s3_bor_ff  <= s2_bor_ff;
         s3_sum8_ff <= sum8;
         s3_ctr_ff  <= cell_out[1].mid;
      end
      o_row_ff  <= o_row_in;
      o_col_ff  <= o_col_in;
      o_val_ff  <= o_val_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = o_row_ff;
   assign rsp_out_col   = o_col_ff;
   assign rsp_out_value = o_val_ff;
   assign rsp_out_last  = o_last_ff;

endmodule

/* design/shp_cell.sv */
// ----------------------------------------------------------------------------
// shp_cell : one column cell of the 3x3 window chain
// Holds three pixels of one column, takes its neighbor's column on shift and
// offers its own column plus the modulo-256 column sum.
// ----------------------------------------------------------------------------
module shp_cell
   import shp_pkg::*;
(
   input  logic              clock,
   input  logic              shift_en,
   input  shp_column_type    col_in,
   output shp_column_type    col_out,
   output logic [PIX_W-1:0]  col_sum
);

   shp_column_type col_ff;
   shp_column_type col_in_sel;

   assign col_in_sel = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in_sel;
   end

   assign col_out = col_ff;
   assign col_sum = col_ff.top + col_ff.mid + col_ff.bot;

endmodule

/* design/shp_line_store.sv */
// ----------------------------------------------------------------------------
// shp_line_store : the two previous-row line memories
// Registered read of both rows at one address; the write in the cycle after
// the read moves the middle row down and stores the new pixel as the middle row.
// ----------------------------------------------------------------------------
module shp_line_store
   import shp_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   input  logic              wr_en,
   input  logic [COL_W-1:0]  wr_addr,
   input  logic [PIX_W-1:0]  wr_px,
   output logic [PIX_W-1:0]  rd_top,
   output logic [PIX_W-1:0]  rd_mid
);

   logic [PIX_W-1:0] row_a_mem [FRAME_WIDTH];   // row r-1
   logic [PIX_W-1:0] row_b_mem [FRAME_WIDTH];   // row r-2
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= row_b_mem[rd_addr];
         mid_ff <= row_a_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_b_mem[wr_addr] <= mid_ff;
         row_a_mem[wr_addr] <= wr_px;
      end
   end

   assign rd_top = top_ff;
   assign rd_mid = mid_ff;

endmodule

/* dv/tb_sharpen_3x3_band_threshold_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sharpen_3x3_band_threshold_core : self-checking bench for the sharpen core
// Streams the first two rows and the start of the third row of a 320x240
// frame through the core, changing gain and band settings over the first
// sharpened pixels, with random pacing on both channels and one long output
// hold. A cycle-free model of the line stores, window and kernel predicts
// every result pixel; results are checked in order.
// ----------------------------------------------------------------------------
module tb_sharpen_3x3_band_threshold_core;
   import shp_pkg::*;

   // long hold on the result side, drain margin and the number of cycles
   // without any transaction before giving up
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = CSR_BAND_ENABLE + 1'b1;

   // how busy a side is: never waits, waits now and then, waits on most items
   typedef enum logic [1:0] {PACE_NONE, PACE_SPARSE, PACE_DENSE} pace_type;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      int               gap;     // idle cycles before this pixel is offered
   } frame_pixel_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic [PIX_W-1:0]     value;
      logic                 last;
   } result_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OUT_ROW_W-1:0]  rsp_out_row;
   logic [OUT_COL_W-1:0]  rsp_out_col;
   logic [PIX_W-1:0]      rsp_out_value;
   logic                  rsp_out_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   sharpen_3x3_band_threshold_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------
   frame_pixel_type  frame_pixels_q[$];   // pixels waiting to be offered
   result_pixel_type due_pixels[$];       // predicted results, oldest first

   pace_type rx_pace      = PACE_DENSE;
   int    hold_request    = 0;         // > 0 asks the receiver for a long hold
   int    stream_pos      = 0;         // pixels queued since reset
   int    pixels_accepted = 0;
   int    results_seen    = 0;
   int    interior_seen   = 0;
   int    border_seen     = 0;
   int    input_held      = 0;         // cycles the core stalled a valid pixel
   int    settings_done   = 0;
   int    failures        = 0;

   // shadow of the register file
   logic [PIX_W-1:0] gain_q      = GAIN_RESET;
   logic [PIX_W-1:0] band_low_q  = BAND_LOW_RESET;
   logic [PIX_W-1:0] band_high_q = BAND_HIGH_RESET;
   logic             band_en_q   = BAND_EN_RESET;

   // shadow of the datapath: previous row, row before that, 3x3 window
   // (window index = 3*row + column, column 2 is the newest)
   logic [PIX_W-1:0] row_back1 [FRAME_WIDTH] = '{default: '0};
   logic [PIX_W-1:0] row_back2 [FRAME_WIDTH] = '{default: '0};
   logic [PIX_W-1:0] win [9] = '{default: '0};
   int               cur_row = 0;
   int               cur_col = 0;

   function automatic int draw_gap(input pace_type pace);
      case (pace)
         PACE_DENSE:  return $urandom_range(0, 11);
         PACE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 11) : 0;
         default:     return 0;
      endcase
   endfunction

   // One accepted pixel: shift the window, update the line stores, then
   // queue the finished interior pixel (r-1,c-1) and/or the border
   // passthrough of (r,c), in that order; last marks the final one.
   task automatic predict_sharpened_pixels(input logic [PIX_W-1:0] px);
      logic [PIX_W-1:0] centre_w;
      logic [PIX_W-1:0] side_w;
      logic [PIX_W-1:0] acc;
      logic             has_inner;
      logic             on_border;
      result_pixel_type res;
      has_inner = (cur_row >= 2) && (cur_col >= 2);
      on_border = (cur_row == 0) || (cur_row == FRAME_HEIGHT - 1) ||
                  (cur_col == 0) || (cur_col == FRAME_WIDTH - 1);
      win[0] = win[1]; win[1] = win[2]; win[2] = row_back2[cur_col];
      win[3] = win[4]; win[4] = win[5]; win[5] = row_back1[cur_col];
      win[6] = win[7]; win[7] = win[8]; win[8] = px;
      row_back2[cur_col] = row_back1[cur_col];
      row_back1[cur_col] = px;
      if (has_inner) begin
         // all weights and the running sum wrap at 8 bits
         centre_w = gain_q + 8'd1;
         side_w   = 8'd0 - (gain_q >> 3);
         acc      = '0;
         for (int i = 0; i < 9; i++)
            acc = acc + ((i == 4) ? centre_w : side_w) * win[i];
         if (band_en_q && (acc > band_high_q || acc < band_low_q))
            acc = '0;
         res.row   = OUT_ROW_W'(cur_row - 1);
         res.col   = OUT_COL_W'(cur_col - 1);
         res.value = acc;
         res.last  = !on_border;
         due_pixels.push_back(res);
      end
      if (on_border) begin
         res.row   = OUT_ROW_W'(cur_row);
         res.col   = OUT_COL_W'(cur_col);
         res.value = px;
         res.last  = 1'b1;
         due_pixels.push_back(res);
      end
      cur_col++;
      if (cur_col == FRAME_WIDTH) begin
         cur_col = 0;
         cur_row++;
         if (cur_row == FRAME_HEIGHT)
            cur_row = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued pixels after each one's idle gap; the pixel
   // is predicted at the edge where it is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : pixel_driver
      int gap_count;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         if (req_valid && req_stall)
            input_held++;
         if (req_valid && !req_stall) begin
            predict_sharpened_pixels(req_pixel_in);
            pixels_accepted++;
         end
         // payload only moves when the current transaction is gone
         if (!req_valid || !req_stall) begin
            if (frame_pixels_q.size() != 0 && gap_count >= frame_pixels_q[0].gap) begin
               req_valid    <= 1'b1;
               req_pixel_in <= frame_pixels_q[0].pixel;
               void'(frame_pixels_q.pop_front());
               gap_count = 0;
            end else begin
               req_valid <= 1'b0;
               if (frame_pixels_q.size() != 0)
                  gap_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each taken result against the oldest prediction, then
   // draws how long to stall before the next one (or serves a long hold).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      result_pixel_type got;
      result_pixel_type want;
      int               stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_row, rsp_out_col, rsp_out_value, rsp_out_last};
            results_seen++;
            if (due_pixels.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("%0t: result (%0d,%0d)=%0d last %0d with nothing outstanding",
                           $realtime, got.row, got.col, got.value, got.last);
               failures++;
            end else begin
               want = due_pixels.pop_front();
               if (want.row == 0 || want.row == FRAME_HEIGHT - 1 ||
                   want.col == 0 || want.col == FRAME_WIDTH - 1)
                  border_seen++;
               else
                  interior_seen++;
               if (got.row !== want.row || got.col !== want.col ||
                   got.value !== want.value || got.last !== want.last) begin
                  if (failures < REPORT_LIMIT)
                     $display("%0t: result %0d expected (%0d,%0d)=%0d last %0d, ",
                              $realtime, results_seen, want.row, want.col, want.value,
                              want.last, "got (%0d,%0d)=%0d last %0d",
                              got.row, got.col, got.value, got.last);
                  failures++;
               end
            end
         end
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (rsp_valid && !rsp_stall) begin
            stall_left = draw_gap(rx_pace);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // any transaction on either channel counts as progress
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_LIMIT, due_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Register writes: one at a time, shadow updated as it lands
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_SHARPEN_GAIN: gain_q      = data;
         CSR_BAND_LOW:     band_low_q  = data;
         CSR_BAND_HIGH:    band_high_q = data;
         CSR_BAND_ENABLE:  band_en_q   = data[0];
         default: ;
      endcase
   endtask

   // First a fixed walk over the corners (identity kernel, max gain with
   // bypass, empty band, single-value bands), then random settings.
   task automatic program_settings();
      logic [PIX_W-1:0] gain;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      logic             en;
      case (settings_done)
         0: begin gain = 8'd0;   lo = 8'd0;   hi = 8'd255; en = 1'b1; end
         1: begin gain = 8'd255; lo = 8'd100; hi = 8'd140; en = 1'b0; end
         2: begin gain = 8'd8;   lo = 8'd200; hi = 8'd50;  en = 1'b1; end
         3: begin gain = 8'd7;   lo = 8'd255; hi = 8'd255; en = 1'b1; end
         4: begin gain = 8'd16;  lo = 8'd0;   hi = 8'd0;   en = 1'b1; end
         5: begin gain = 8'd1;   lo = 8'd100; hi = 8'd140; en = 1'b1; end
         default: begin
            gain = PIX_W'($urandom);
            lo   = PIX_W'($urandom);
            // mostly a sane band so some values survive
            hi   = ($urandom_range(0, 3) != 0) ? lo + PIX_W'($urandom_range(0, 255 - lo))
                                               : PIX_W'($urandom);
            en   = ($urandom_range(0, 3) != 0);
         end
      endcase
      write_reg(CSR_SHARPEN_GAIN, gain);
      write_reg(CSR_BAND_LOW, lo);
      write_reg(CSR_BAND_HIGH, hi);
      // upper data bits are junk for the 1-bit register
      write_reg(CSR_BAND_ENABLE, {7'($urandom), en});
      // writes to unmapped indexes must not disturb anything
      if (settings_done[0])
         write_reg(CSR_FIRST_UNMAPPED + CSR_IDX_W'($urandom_range(0, 3)), CSR_DATA_W'($urandom));
      settings_done++;
   endtask

   // Queue a run of pixels, then wait until all are taken, every result is
   // back, and the pipe has had time to settle (pixels with no result).
   task automatic stream_pixels(input int count, input pace_type pace, input logic directed);
      frame_pixel_type  item;
      logic [PIX_W-1:0] base;
      logic [PIX_W-1:0] corner_px [8];
      corner_px = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F};
      base      = PIX_W'($urandom);
      rx_pace   = pace;
      for (int i = 0; i < count; i++) begin
         if (directed && i < 8) begin
            item.pixel = corner_px[i];
         end else begin
            // extremes, smooth patches near a level, and noise
            case ($urandom_range(0, 7))
               0:       item.pixel = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
               1, 2, 3: item.pixel = base + PIX_W'($urandom_range(0, 7));
               default: item.pixel = PIX_W'($urandom);
            endcase
         end
         item.gap = draw_gap(pace);
         frame_pixels_q.push_back(item);
      end
      stream_pos += count;
      // a missing result keeps this loop spinning until the watchdog fires
      while (pixels_accepted != stream_pos || due_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus. Positions are counted in pixels from the top left of the
   // frame; the first sharpened pixel comes with row 2, column 2.
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // start of row 0 under reset settings: pixel extremes first, all passthrough
      stream_pixels(24, PACE_DENSE, 1'b1);

      // rest of rows 0 and 1 and the first two pixels of row 2 (one border pixel)
      stream_pixels(2 * FRAME_WIDTH + 2 - stream_pos, PACE_SPARSE, 1'b0);

      // short runs of sharpened pixels with new settings for each run; one
      // run at full rate with a long output hold so the core backs up and
      // stalls its input
      for (int k = 0; k < 9; k++) begin
         program_settings();
         if (k == 4) begin
            hold_request = HOLD_CYCLES;
            stream_pixels(12, PACE_NONE, 1'b0);
         end else begin
            stream_pixels(12, k[0] ? PACE_DENSE : PACE_SPARSE, 1'b0);
         end
      end

      repeat (4 * DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d pixels (rows 0 and 1 of a %0dx%0d frame and the start of row 2), ",
               pixels_accepted, FRAME_WIDTH, FRAME_HEIGHT,
               "checked %0d results: %0d sharpened, %0d border.",
               results_seen, interior_seen, border_seen);
      $display("%0d register settings applied; input back-pressured for %0d cycles; %0d mismatches.",
               settings_done, input_held, failures);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
design/shp_pkg.sv
design/shp_cell.sv
design/shp_line_store.sv
design/sharpen_3x3_band_threshold_core.sv
dv/tb_sharpen_3x3_band_threshold_core.sv
